// File: hdl/mwsum_pkg.sv
package mwsum_pkg;

   // fixed field widths
   localparam int CELL_W     = 8;
   localparam int DIM_W      = 11;
   localparam int WROWS_W    = 6;
   localparam int BEST_W     = 23;
   localparam int RSP_DATA_W = 24;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_ROWS = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_COLS = 8'd3;

   // clamped register set in use
   typedef struct packed {
      logic [DIM_W-1:0]   grid_height;
      logic [DIM_W-1:0]   grid_width;
      logic [WROWS_W-1:0] window_rows;
      logic [DIM_W-1:0]   window_cols;
   } cfg_type;

   // per-item control traveling down the pipeline
   typedef struct packed {
      logic valid;
      logic col_first;
      logic in_window;
      logic frame_end;
   } ctl_type;

endpackage

// File: hdl/mwsum_cfg.sv
module mwsum_cfg
   import mwsum_pkg::*;
#(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_HEIGHT      = 1024,
   parameter int MAX_WINDOW_ROWS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg,
   output logic                  restart
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    csr_write;

   // zero reads as one, anything above the limit as the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (int'(v) > hi) begin
         res = DIM_W'(hi);
      end else begin
         res = v;
      end
      return res;
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // register decode; a write to a known register restarts the frame
   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_write) begin
         case (csr_index)
            REG_GRID_HEIGHT: begin
               cfg_in.grid_height = clamp_dim(csr_data[DIM_W-1:0], MAX_HEIGHT);
               restart = 1'b1;
            end
            REG_GRID_WIDTH: begin
               cfg_in.grid_width = clamp_dim(csr_data[DIM_W-1:0], MAX_WIDTH);
               restart = 1'b1;
            end
            REG_WINDOW_ROWS: begin
               cfg_in.window_rows = WROWS_W'(clamp_dim(DIM_W'(csr_data[WROWS_W-1:0]),
                                                       MAX_WINDOW_ROWS));
               restart = 1'b1;
            end
            REG_WINDOW_COLS: begin
               cfg_in.window_cols = clamp_dim(csr_data[DIM_W-1:0], MAX_WIDTH);
               restart = 1'b1;
            end
            default: begin
               cfg_in  = cfg_ff;
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_height <= DIM_W'(1);
         cfg_ff.grid_width  <= DIM_W'(1);
         cfg_ff.window_rows <= WROWS_W'(1);
         cfg_ff.window_cols <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/mwsum_col.sv
module mwsum_col
   import mwsum_pkg::*;
#(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_HEIGHT      = 1024,
   parameter int MAX_WINDOW_ROWS = 32,
   localparam int CSW            = $clog2(MAX_WINDOW_ROWS * 255 + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  cfg_type           cfg,
   input  logic              adv,
   input  logic              cell_accept,
   input  logic [CELL_W-1:0] cell_value,
   output ctl_type           p2_ctl,
   output logic [CSW-1:0]    p2_col_sum,
   output logic [CSW-1:0]    p2_drop_sum
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RCW  = $clog2(MAX_HEIGHT);
   localparam int SW   = (MAX_WINDOW_ROWS > 1) ? $clog2(MAX_WINDOW_ROWS) : 1;
   localparam int BIG  = (CW > RCW) ? CW : RCW;
   localparam int CMPW = ((BIG > DIM_W) ? BIG : DIM_W) + 1;

   // line store and column sums
   logic [CELL_W-1:0] row_mem [MAX_WINDOW_ROWS][MAX_WIDTH];
   logic [CSW-1:0]    cs_mem  [MAX_WIDTH];

   // raster position
   logic [RCW-1:0] row_ff,  row_in;
   logic [CW-1:0]  col_ff,  col_in;
   logic [SW-1:0]  slot_ff, slot_in;
   logic [SW-1:0]  old_ff,  old_in;

   logic [CMPW-1:0] col_x, row_x, gw_x, gh_x, wr_x, wc_x, diff_x;
   logic            row_end, frame_end, drop_old, drop_col, in_window;
   logic [CW-1:0]   drop_addr;
   logic [SW-1:0]   slot_inc, old_inc;
   logic            hit_cs, hit_drop, hit_old;

   // first pipeline stage
   ctl_type           p1_ctl_ff;
   logic [CELL_W-1:0] p1_value_ff;
   logic [CW-1:0]     p1_col_ff;
   logic [SW-1:0]     p1_slot_ff;
   logic              p1_first_row_ff, p1_drop_old_ff, p1_drop_col_ff;
   logic [CSW-1:0]    cs_rd_ff, drop_rd_ff, fwd_sum_ff;
   logic [CELL_W-1:0] old_rd_ff, fwd_cell_ff;
   logic              fwd_cs_ff, fwd_drop_ff, fwd_old_ff;

   logic [CSW-1:0]    cs_prev, new_sum, drop_sum, old_sub;
   logic [CELL_W-1:0] old_cell;

   // second stage
   ctl_type        p2_ctl_ff;
   logic [CSW-1:0] p2_col_sum_ff, p2_drop_sum_ff;

   // position decode
   always_comb begin
      col_x     = CMPW'(col_ff);
      row_x     = CMPW'(row_ff);
      gw_x      = CMPW'(cfg.grid_width);
      gh_x      = CMPW'(cfg.grid_height);
      wr_x      = CMPW'(cfg.window_rows);
      wc_x      = CMPW'(cfg.window_cols);
      row_end   = (col_x + 1'b1) >= gw_x;
      frame_end = row_end && ((row_x + 1'b1) >= gh_x);
      drop_old  = row_x >= wr_x;
      drop_col  = col_x >= wc_x;
      in_window = ((row_x + 1'b1) >= wr_x) && ((col_x + 1'b1) >= wc_x);
      diff_x    = col_x - wc_x;
      drop_addr = diff_x[CW-1:0];
      slot_inc  = (slot_ff == SW'(MAX_WINDOW_ROWS - 1)) ? '0 : slot_ff + 1'b1;
      old_inc   = (old_ff == SW'(MAX_WINDOW_ROWS - 1)) ? '0 : old_ff + 1'b1;
   end

   // raster advance
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      slot_in = slot_ff;
      old_in  = old_ff;
      if (restart) begin
         row_in  = '0;
         col_in  = '0;
         slot_in = '0;
         old_in  = '0;
      end else if (cell_accept) begin
         if (!row_end) begin
            col_in = col_ff + 1'b1;
         end else if (frame_end) begin
            col_in  = '0;
            row_in  = '0;
            slot_in = '0;
            old_in  = '0;
         end else begin
            col_in  = '0;
            row_in  = row_ff + 1'b1;
            slot_in = slot_inc;
            old_in  = drop_old ? old_inc : old_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
         old_ff  <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         slot_ff <= slot_in;
         old_ff  <= old_in;
      end
   end

   // the item in stage one writes this cycle, so its data bypasses the memories
   assign hit_cs   = p1_ctl_ff.valid && (p1_col_ff == col_ff);
   assign hit_drop = p1_ctl_ff.valid && (p1_col_ff == drop_addr);
   assign hit_old  = p1_ctl_ff.valid && (p1_col_ff == col_ff) && (p1_slot_ff == old_ff);

   // column sum memory: one write, two reads
   always_ff @(posedge clock) begin
      if (adv) begin
         cs_rd_ff   <= cs_mem[col_ff];
         drop_rd_ff <= cs_mem[drop_addr];
         if (p1_ctl_ff.valid) begin
            cs_mem[p1_col_ff] <= new_sum;
         end
      end
   end

   // line store: one write, one read
   always_ff @(posedge clock) begin
      if (adv) begin
         old_rd_ff <= row_mem[old_ff][col_ff];
         if (p1_ctl_ff.valid) begin
            row_mem[p1_slot_ff][p1_col_ff] <= p1_value_ff;
         end
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_value_ff     <= cell_value;
         p1_col_ff       <= col_ff;
         p1_slot_ff      <= slot_ff;
         p1_first_row_ff <= (row_ff == '0);
         p1_drop_old_ff  <= drop_old;
         p1_drop_col_ff  <= drop_col;
         fwd_cs_ff       <= hit_cs;
         fwd_drop_ff     <= hit_drop;
         fwd_old_ff      <= hit_old;
         fwd_sum_ff      <= new_sum;
         fwd_cell_ff     <= p1_value_ff;
      end
   end

   // stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff <= '0;
      end else if (adv) begin
         p1_ctl_ff.valid     <= cell_accept;
         p1_ctl_ff.col_first <= (col_ff == '0);
         p1_ctl_ff.in_window <= in_window;
         p1_ctl_ff.frame_end <= frame_end;
      end
   end

   // new column sum: add the cell, drop the one leaving the window
   always_comb begin
      cs_prev  = fwd_cs_ff ? fwd_sum_ff : cs_rd_ff;
      old_cell = fwd_old_ff ? fwd_cell_ff : old_rd_ff;
      old_sub  = p1_drop_old_ff ? CSW'(old_cell) : '0;
      if (p1_first_row_ff) begin
         new_sum = CSW'(p1_value_ff);
      end else begin
         new_sum = cs_prev + CSW'(p1_value_ff) - old_sub;
      end
      if (p1_drop_col_ff) begin
         drop_sum = fwd_drop_ff ? fwd_sum_ff : drop_rd_ff;
      end else begin
         drop_sum = '0;
      end
   end

   // stage two
   always_ff @(posedge clock) begin
      if (adv) begin
         p2_col_sum_ff  <= new_sum;
         p2_drop_sum_ff <= drop_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ctl_ff <= '0;
      end else if (adv) begin
         p2_ctl_ff <= p1_ctl_ff;
      end
   end

   assign p2_ctl      = p2_ctl_ff;
   assign p2_col_sum  = p2_col_sum_ff;
   assign p2_drop_sum = p2_drop_sum_ff;

`ifndef SYNTHESIS
   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      CMPW'(col_ff) < CMPW'(cfg.grid_width))
      else $error("column counter outside grid");

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      CMPW'(row_ff) < CMPW'(cfg.grid_height))
      else $error("row counter outside grid");
`endif

endmodule

// File: hdl/mwsum_box.sv
module mwsum_box
   import mwsum_pkg::*;
#(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_WINDOW_ROWS = 32,
   localparam int CSW            = $clog2(MAX_WINDOW_ROWS * 255 + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  ctl_type               p2_ctl,
   input  logic [CSW-1:0]        p2_col_sum,
   input  logic [CSW-1:0]        p2_drop_sum,
   output logic                  adv,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int HSW = $clog2(MAX_WIDTH * MAX_WINDOW_ROWS * 255 + 1);

   logic [HSW-1:0]    hs_ff, hs_in;
   ctl_type           p3_ctl_ff;
   logic [HSW-1:0]    best_ff, best_next;
   logic              any_ff, any_next, take;
   logic              rsp_valid_ff;
   logic [BEST_W-1:0] rsp_best_ff;
   logic              rsp_found_ff;

   // hold the pipe only when a frame result has nowhere to go
   assign adv = !(p3_ctl_ff.valid && p3_ctl_ff.frame_end && rsp_valid_ff && !rsp_tready);

   // running sum of the last window_cols column sums
   assign hs_in = (p2_ctl.col_first ? '0 : hs_ff) + HSW'(p2_col_sum) - HSW'(p2_drop_sum);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         hs_ff <= '0;
      end else if (adv && p2_ctl.valid) begin
         hs_ff <= hs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_ctl_ff <= '0;
      end else if (adv) begin
         p3_ctl_ff <= p2_ctl;
      end
   end

   // best window so far
   always_comb begin
      take      = p3_ctl_ff.valid && p3_ctl_ff.in_window && (!any_ff || (hs_ff > best_ff));
      best_next = take ? hs_ff : best_ff;
      any_next  = any_ff | (p3_ctl_ff.valid & p3_ctl_ff.in_window);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         best_ff <= '0;
         any_ff  <= 1'b0;
      end else if (adv && p3_ctl_ff.valid) begin
         if (p3_ctl_ff.frame_end) begin
            best_ff <= '0;
            any_ff  <= 1'b0;
         end else begin
            best_ff <= best_next;
            any_ff  <= any_next;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && p3_ctl_ff.valid && p3_ctl_ff.frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && p3_ctl_ff.valid && p3_ctl_ff.frame_end) begin
         rsp_best_ff  <= BEST_W'(best_next);
         rsp_found_ff <= any_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_best_ff);
   assign rsp_tuser  = rsp_found_ff;

`ifndef SYNTHESIS
   a_none_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_best_ff == '0))
      else $error("empty result carries a nonzero sum");

   a_hold_sum: assert property (@(posedge clock) disable iff (reset)
      (!adv && !restart) |=> $stable(hs_ff))
      else $error("running sum moved while the pipe was held");
`endif

endmodule

// File: hdl/max_window_sum_2d_core.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata[7:0] cell_value
// rsp      out        rsp_tvalid/rsp_tready  tdata[22:0] best_sum, tuser found
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One cell per cycle except while input is held. A frame's result is registered after its last
// cell is taken and has passed, in order, the column-sum memory read, the column update and
// the box sum update, each of which takes one stage, and then the best-window check.
// Reset is synchronous; the line store and column-sum memory have no reset
// and need no clearing pass.
// Input is held only while the last cell of a frame waits at the final stage
// behind an unread result.
module max_window_sum_2d_core
   import mwsum_pkg::*;
#(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_HEIGHT      = 1024,
   parameter int MAX_WINDOW_ROWS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CELL_W-1:0]     req_tdata,    // [7:0] cell_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [22:0] best_sum, [23] zero
   output logic                  rsp_tuser,    // [0] found
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CSW = $clog2(MAX_WINDOW_ROWS * 255 + 1);

   cfg_type        cfg;
   logic           restart;
   logic           adv;
   ctl_type        p2_ctl;
   logic [CSW-1:0] p2_col_sum;
   logic [CSW-1:0] p2_drop_sum;

   assign req_tready = adv;

   mwsum_cfg #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .MAX_WINDOW_ROWS (MAX_WINDOW_ROWS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .restart   (restart)
   );

   mwsum_col #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .MAX_WINDOW_ROWS (MAX_WINDOW_ROWS)
   ) u_col (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .cfg         (cfg),
      .adv         (adv),
      .cell_accept (req_tvalid & adv),
      .cell_value  (req_tdata),
      .p2_ctl      (p2_ctl),
      .p2_col_sum  (p2_col_sum),
      .p2_drop_sum (p2_drop_sum)
   );

   mwsum_box #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_WINDOW_ROWS (MAX_WINDOW_ROWS)
   ) u_box (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .p2_ctl      (p2_ctl),
      .p2_col_sum  (p2_col_sum),
      .p2_drop_sum (p2_drop_sum),
      .adv         (adv),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// File: verif/max_window_sum_2d_core_tb.sv
module max_window_sum_2d_core_tb;
   import mwsum_pkg::*;

   localparam int GRID_MAX     = 1024;
   localparam int WIN_ROWS_MAX = 32;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_CELLS = 760;

   // first register index past the defined set; writes there are ignored
   localparam logic [CSR_IDX_W-1:0] REG_PAST_END = REG_WINDOW_COLS + 8'd1;

   typedef struct {
      logic [BEST_W-1:0] best_sum;
      logic              found;
   } box_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CELL_W-1:0]     req_tdata = '0;    // [7:0] cell_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [22:0] best_sum, [23] zero
   logic                  rsp_tuser;         // [0] found
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   max_window_sum_2d_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and scoreboard bookkeeping
   logic [CELL_W-1:0] cell_queue [$];
   box_result_type    box_results [$];
   int                cells_sent = 0;
   int                cells_taken = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                error_count = 0;

   // predicted block state, clamped registers in use
   int                grid_h = 1;
   int                grid_w = 1;
   int                win_rows = 1;
   int                win_cols = 1;
   logic [CELL_W-1:0] line_buf [WIN_ROWS_MAX][GRID_MAX];
   int                col_sum [GRID_MAX];
   int                run_sum = 0;
   int                row_pos = 0;
   int                col_pos = 0;
   int                best_box = 0;
   logic              have_window = 1'b0;

   function automatic int clamp_dim(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      run_sum = 0;
      row_pos = 0;
      col_pos = 0;
      best_box = 0;
      have_window = 1'b0;
   endfunction

   // register write: valid index clamps its value and abandons the frame
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      logic known;
      known = 1'b1;
      case (idx)
         REG_GRID_HEIGHT: grid_h = clamp_dim(int'(data), GRID_MAX);
         REG_GRID_WIDTH:  grid_w = clamp_dim(int'(data), GRID_MAX);
         REG_WINDOW_ROWS: win_rows = clamp_dim(int'(data[WROWS_W-1:0]), WIN_ROWS_MAX);
         REG_WINDOW_COLS: win_cols = clamp_dim(int'(data), GRID_MAX);
         default: known = 1'b0;
      endcase
      if (known) restart_frame();
   endfunction

   // one cell: update column and box sums, emit the frame result at its end
   function automatic void accept_cell(input logic [CELL_W-1:0] v);
      int r;
      int c;
      box_result_type res;
      r = row_pos;
      c = col_pos;
      if (r == 0) begin
         col_sum[c] = v;
      end else begin
         col_sum[c] += v;
         if (r >= win_rows) col_sum[c] -= line_buf[(r - win_rows) % WIN_ROWS_MAX][c];
      end
      line_buf[r % WIN_ROWS_MAX][c] = v;

      if (c == 0) run_sum = 0;
      run_sum += col_sum[c];
      if (c >= win_cols) run_sum -= col_sum[c - win_cols];

      if (r + 1 >= win_rows && c + 1 >= win_cols) begin
         if (!have_window || run_sum > best_box) best_box = run_sum;
         have_window = 1'b1;
      end

      if (c + 1 >= grid_w) begin
         col_pos = 0;
         if (r + 1 >= grid_h) begin
            res.best_sum = best_box[BEST_W-1:0];
            res.found = have_window;
            box_results.push_back(res);
            restart_frame();
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // cell driver: hold while stalled, otherwise present the next queued cell or go idle at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accept_cell(req_tdata);
            cells_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (cell_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= cell_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : rsp_monitor
      box_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (box_results.size() == 0) begin
               $error("unexpected result: best_sum %0d found %0d",
                      rsp_tdata[BEST_W-1:0], rsp_tuser);
               error_count++;
            end else begin
               want = box_results.pop_front();
               if (rsp_tdata[BEST_W-1:0] !== want.best_sum) begin
                  $error("best_sum: expected %0d actual %0d",
                         want.best_sum, rsp_tdata[BEST_W-1:0]);
                  error_count++;
               end
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0d actual %0d", want.found, rsp_tuser);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      apply_reg(idx, data);
   endtask

   // all cells taken, all results back, pipeline drained
   task automatic wait_quiet();
      while (cells_taken != cells_sent || box_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_cfg(input logic [CSR_DATA_W-1:0] gh, input logic [CSR_DATA_W-1:0] gw,
                          input logic [CSR_DATA_W-1:0] wr, input logic [CSR_DATA_W-1:0] wc);
      int first;
      first = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
         case ((first + k) % 4)
            0: write_reg(REG_GRID_HEIGHT, gh);
            1: write_reg(REG_GRID_WIDTH, gw);
            2: write_reg(REG_WINDOW_ROWS, wr);
            default: write_reg(REG_WINDOW_COLS, wc);
         endcase
      end
   endtask

   // flavor 0: all max, 1: all zero, 2: tiny values, else uniform
   task automatic push_cells(input int n, input int flavor);
      logic [CELL_W-1:0] v;
      for (int k = 0; k < n; k++) begin
         case (flavor)
            0: v = '1;
            1: v = '0;
            2: v = CELL_W'($urandom_range(0, 3));
            default: v = CELL_W'($urandom_range(0, 255));
         endcase
         cell_queue.push_back(v);
         cells_sent++;
      end
   endtask

   task automatic push_list(input logic [CELL_W-1:0] a, input logic [CELL_W-1:0] b,
                            input logic [CELL_W-1:0] c, input int n);
      if (n > 0) cell_queue.push_back(a);
      if (n > 1) cell_queue.push_back(b);
      if (n > 2) cell_queue.push_back(c);
      cells_sent += n;
   endtask

   task automatic pick_pace();
      case ($urandom_range(0, 3))
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 71; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 71; end
         default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
   endtask

   // random geometry, sometimes with raw values that need clamping
   task automatic random_config();
      int gh;
      int gw;
      int wr;
      int wc;
      logic [CSR_DATA_W-1:0] raw_h;
      logic [CSR_DATA_W-1:0] raw_w;
      logic [CSR_DATA_W-1:0] raw_wr;
      logic [CSR_DATA_W-1:0] raw_wc;
      if ($urandom_range(99) < 8) begin
         // tall grid: line store wraps past its row count
         gh = $urandom_range(33, 40);
         gw = $urandom_range(1, 4);
         wr = $urandom_range(20, WIN_ROWS_MAX);
      end else begin
         gh = $urandom_range(1, 8);
         gw = $urandom_range(1, 12);
         wr = $urandom_range(1, gh + 1);
      end
      wc = $urandom_range(1, gw + 1);
      raw_h = CSR_DATA_W'(gh);
      raw_w = CSR_DATA_W'(gw);
      raw_wr = {5'($urandom), 6'(wr)};
      raw_wc = CSR_DATA_W'(wc);
      if (gh == 1 && $urandom_range(1)) raw_h = '0;
      if (gw == 1 && $urandom_range(1)) raw_w = '0;
      if (wr == 1 && $urandom_range(1)) raw_wr[WROWS_W-1:0] = '0;
      if (wr == WIN_ROWS_MAX && $urandom_range(1))
         raw_wr[WROWS_W-1:0] = WROWS_W'($urandom_range(WIN_ROWS_MAX + 1, 63));
      if (wc > gw && $urandom_range(1)) raw_wc = CSR_DATA_W'($urandom_range(GRID_MAX + 1, 2047));
      set_cfg(raw_h, raw_w, raw_wr, raw_wc);
      if ($urandom_range(4) == 0)
         write_reg(CSR_IDX_W'($urandom_range(REG_PAST_END, {CSR_IDX_W{1'b1}})),
                   CSR_DATA_W'($urandom));
   endtask

   initial begin : stimulus
      int random_cells;
      int frame_cells;
      int n;
      logic need_cfg;
      random_cells = 0;
      need_cfg = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry is a single cell with a single-cell window
      push_list(8'h00, 8'hFF, 8'h00, 2);
      wait_quiet();

      // window taller than the grid: no window fits
      set_cfg('0, 11'd3, 11'd2, 11'd1);
      push_list(8'hFF, 8'hFF, 8'hFF, 3);
      wait_quiet();

      // write to an undefined index mid-frame leaves the frame running
      set_cfg(11'd2, 11'd2, 11'd1, 11'd1);
      push_list(8'hFF, 8'h00, 8'h80, 3);
      wait_quiet();
      write_reg(REG_PAST_END, 11'd5);
      push_list(8'h7F, 8'h00, 8'h00, 1);
      wait_quiet();

      // valid write mid-frame abandons the partial frame
      push_list(8'hFF, 8'hFF, 8'h00, 2);
      wait_quiet();
      write_reg(REG_WINDOW_COLS, 11'd2);
      push_list(8'h01, 8'h55, 8'hAA, 3);
      push_list(8'hFE, 8'h00, 8'h00, 1);
      wait_quiet();

      // window wider than the grid
      set_cfg(11'd1, 11'd2, 11'd1, 11'd5);
      push_list(8'hFF, 8'hFF, 8'h00, 2);
      wait_quiet();

      // tallest window of max cells, oversize window height clamped
      send_idle_pct = 0;
      stall_pct = 0;
      set_cfg(11'd32, 11'd3, 11'h7FF, 11'd2);
      push_cells(WIN_ROWS_MAX * 3, 0);
      wait_quiet();

      // tall grid, one column: line store wraps
      pick_pace();
      set_cfg(11'd40, 11'd1, 11'd32, 11'd1);
      push_cells(40, 3);
      wait_quiet();

      // oversize grid clamped; partial frame dropped by the next setup
      pick_pace();
      set_cfg(11'd2047, 11'd1500, 11'd32, 11'd2047);
      push_cells(40, 3);
      wait_quiet();

      // random frames, a few abandoned part way
      while (random_cells < RANDOM_CELLS) begin
         pick_pace();
         if (need_cfg || $urandom_range(99) < 60) random_config();
         need_cfg = 1'b0;
         frame_cells = grid_h * grid_w;
         if (frame_cells > 1 && $urandom_range(9) == 0) begin
            n = $urandom_range(1, frame_cells - 1);
            push_cells(n, $urandom_range(0, 9));
            random_cells += n;
            need_cfg = 1'b1;
         end else begin
            n = $urandom_range(1, 3);
            for (int f = 0; f < n; f++) push_cells(frame_cells, $urandom_range(0, 9));
            random_cells += n * frame_cells;
         end
         wait_quiet();
      end

      repeat (20) @(negedge clock);
      if (box_results.size() != 0) begin
         $error("%0d frame results never arrived", box_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hdl/mwsum_pkg.sv
hdl/mwsum_cfg.sv
hdl/mwsum_col.sv
hdl/mwsum_box.sv
hdl/max_window_sum_2d_core.sv
verif/max_window_sum_2d_core_tb.sv
